// ===== hdl/bdb_pkg.sv =====
// Shared types and constants for the button short/long press debouncer.
// Used by the configuration block, the per-button machine and the top level.
// No dependencies.
`default_nettype none

package bdb_pkg;

	// number of buttons, fixed by the named pin and event fields
	localparam int NUM_BUTTONS = 3;

	localparam int BOUNCE_W = 10;
	localparam int HOLD_W   = 16;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	localparam logic [BOUNCE_W-1:0] BOUNCE_RESET = 10'd100;
	localparam logic [HOLD_W-1:0]   HOLD_RESET   = 16'd1000;

	// register index, taken from paddr[2]
	localparam logic REG_BOUNCE = 1'b0;
	localparam logic REG_HOLD   = 1'b1;

	// event codes
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_SHORT = 2'd1;
	localparam logic [1:0] EV_LONG  = 2'd2;

	typedef struct packed {
		logic [BOUNCE_W-1:0] bounce;   // bounce wait in ticks
		logic [HOLD_W-1:0]   thr;      // pressing ticks before a long press
	} cfg_t;

endpackage

`default_nettype wire

// ===== hdl/bdb_if.sv =====
// Valid/ready channel interfaces: the tick input and the result output.
// No dependencies.
`default_nettype none

interface bdb_tick_if;
	logic valid;
	logic ready;
	logic pin_one_level;
	logic pin_two_level;
	logic pin_three_level;

	modport source (output valid, output pin_one_level, output pin_two_level,
		output pin_three_level, input ready);
	modport sink (input valid, input pin_one_level, input pin_two_level,
		input pin_three_level, output ready);
endinterface

interface bdb_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] one_event;
	logic [1:0] two_event;
	logic [1:0] three_event;
	logic       one_down;
	logic       two_down;
	logic       three_down;

	modport source (output valid, output one_event, output two_event,
		output three_event, output one_down, output two_down, output three_down,
		input ready);
	modport sink (input valid, input one_event, input two_event,
		input three_event, input one_down, input two_down, input three_down,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/bdb_cfg.sv =====
// APB register block: bounce_ticks and hold_ticks, plus the derived hold threshold.
// Depends on bdb_pkg.
`default_nettype none

module bdb_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bdb_pkg::APB_AW-1:0]   paddr,
	input  wire logic [bdb_pkg::APB_DW-1:0]   pwdata,
	output logic      [bdb_pkg::APB_DW-1:0]   prdata,
	output logic                              pready,
	output bdb_pkg::cfg_t                     cfg
);

	logic [bdb_pkg::BOUNCE_W-1:0] bounce_q;
	logic [bdb_pkg::HOLD_W-1:0]   hold_q;
	logic                         idx;
	logic                         wr;

	assign pready = 1'b1;
	assign idx    = paddr[2];
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounce_q <= bdb_pkg::BOUNCE_RESET;
			hold_q   <= bdb_pkg::HOLD_RESET;
		end else if (wr) begin
			unique case (idx)
				bdb_pkg::REG_BOUNCE: bounce_q <= pwdata[bdb_pkg::BOUNCE_W-1:0];
				bdb_pkg::REG_HOLD:   hold_q   <= pwdata[bdb_pkg::HOLD_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			bdb_pkg::REG_BOUNCE: prdata = bdb_pkg::APB_DW'(bounce_q);
			bdb_pkg::REG_HOLD:   prdata = bdb_pkg::APB_DW'(hold_q);
		endcase
	end

	// hold minus bounce, floored at zero
	assign cfg.bounce = bounce_q;
	assign cfg.thr    = (hold_q > bdb_pkg::HOLD_W'(bounce_q))
		? hold_q - bdb_pkg::HOLD_W'(bounce_q) : '0;

endmodule

`default_nettype wire

// ===== hdl/bdb_button.sv =====
// Per-button four-phase debounce machine with a saturating tick counter.
// Depends on bdb_pkg.
`default_nettype none

module bdb_button #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          tick_en,
	input  wire logic          pressed,
	input  bdb_pkg::cfg_t      cfg,
	output logic [1:0]         ev,
	output logic               down
);

	localparam logic [1:0] PH_WAIT  = 2'd0;
	localparam logic [1:0] PH_FRONT = 2'd1;
	localparam logic [1:0] PH_PRESS = 2'd2;
	localparam logic [1:0] PH_REAR  = 2'd3;

	localparam int CMP_W = (COUNT_WIDTH > bdb_pkg::HOLD_W) ? COUNT_WIDTH : bdb_pkg::HOLD_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [1:0]             phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] elapsed_q, elapsed_d, cnt_inc;
	logic                   seen_q, seen_d;
	logic [CMP_W-1:0]       inc_ext, bounce_ext, thr_ext;

	assign cnt_inc    = (elapsed_q == CNT_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign inc_ext    = CMP_W'(cnt_inc);
	assign bounce_ext = CMP_W'(cfg.bounce);
	assign thr_ext    = CMP_W'(cfg.thr);

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		seen_d    = seen_q;
		ev        = bdb_pkg::EV_NONE;
		unique case (phase_q)
			PH_WAIT: begin
				if (pressed) begin
					phase_d   = PH_FRONT;
					seen_d    = 1'b1;
					elapsed_d = '0;
				end
			end
			PH_FRONT: begin
				elapsed_d = cnt_inc;
				if (inc_ext > bounce_ext) begin
					phase_d   = PH_PRESS;
					elapsed_d = '0;
				end
			end
			PH_PRESS: begin
				elapsed_d = cnt_inc;
				if (!pressed)
					ev = bdb_pkg::EV_SHORT;
				else if (inc_ext > thr_ext)
					ev = bdb_pkg::EV_LONG;
				if (ev != bdb_pkg::EV_NONE) begin
					phase_d   = PH_REAR;
					seen_d    = 1'b0;
					elapsed_d = '0;
				end
			end
			PH_REAR: begin
				// counts while still held, leaves only after release
				elapsed_d = cnt_inc;
				if (!pressed && inc_ext > bounce_ext)
					phase_d = PH_WAIT;
			end
		endcase
	end

	assign down = seen_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAIT;
			elapsed_q <= '0;
			seen_q    <= 1'b0;
		end else if (tick_en) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			seen_q    <= seen_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/button_short_long_press_debouncer_top.sv =====
// Top level of the three-button short/long press debouncer: APB registers,
// one debounce machine per button and the registered result stage.
// Depends on bdb_pkg, bdb_if, bdb_cfg and bdb_button.
`default_nettype none

// Each tick transfer updates all button machines in the cycle it is taken and
// leaves exactly one result in the result register from the next cycle on, where
// it holds until its own transfer. A tick is taken every cycle as long as the
// result register is empty or being drained in the same cycle, so the sustained
// rate is one tick per clock; the result register is the only stage between the
// two channels. bounce_ticks sits at byte address 0 and hold_ticks at 4; write
// them only while no tick is in flight.
module button_short_long_press_debouncer_top #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bdb_pkg::APB_AW-1:0] paddr,
	input  wire logic [bdb_pkg::APB_DW-1:0] pwdata,
	output logic      [bdb_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	bdb_tick_if.sink                        tick,
	bdb_result_if.source                    result
);

	localparam int NB = bdb_pkg::NUM_BUTTONS;

	bdb_pkg::cfg_t   cfg;
	logic            tick_en;
	logic [NB-1:0]   pressed;
	logic [1:0]      ev   [NB];
	logic [NB-1:0]   down;

	logic            valid_q;
	logic [1:0]      ev_q [NB];
	logic [NB-1:0]   down_q;

	bdb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pins are active low
	assign pressed = ~{tick.pin_three_level, tick.pin_two_level, tick.pin_one_level};

	assign tick.ready = !valid_q || result.ready;
	assign tick_en    = tick.valid && tick.ready;

	for (genvar b = 0; b < NB; b++) begin : g_btn
		bdb_button #(
			.COUNT_WIDTH (COUNT_WIDTH)
		) u_btn (
			.clk     (clk),
			.arst_n  (arst_n),
			.tick_en (tick_en),
			.pressed (pressed[b]),
			.cfg     (cfg),
			.ev      (ev[b]),
			.down    (down[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (tick.ready)
			valid_q <= tick.valid;
	end

	always_ff @(posedge clk) begin
		if (tick_en) begin
			ev_q   <= ev;
			down_q <= down;
		end
	end

	assign result.valid       = valid_q;
	assign result.one_event   = ev_q[0];
	assign result.two_event   = ev_q[1];
	assign result.three_event = ev_q[2];
	assign result.one_down    = down_q[0];
	assign result.two_down    = down_q[1];
	assign result.three_down  = down_q[2];

	// every accepted tick leaves a result waiting in the next cycle
	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick_en |=> result.valid)
		else $error("tick transfer without a following result");

	// an event ends the press, so button one's down flag must already be cleared
	a_ev_clears_down: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.one_event != bdb_pkg::EV_NONE) |-> !result.one_down)
		else $error("button one event with down still set");

	a_ev_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.one_event != 2'd3) && (result.two_event != 2'd3)
			&& (result.three_event != 2'd3))
		else $error("undefined event code");

endmodule

`default_nettype wire

// ===== verif/tb_button_short_long_press_debouncer_top.sv =====
// Self-checking testbench for the three-button short/long press debouncer.
// Drives tick transfers and APB register writes, predicts every result in place.
// Depends on bdb_pkg, bdb_if and button_short_long_press_debouncer_top.

module tb_button_short_long_press_debouncer_top;

	localparam int CNT_W = 16;
	localparam int MAX_REPORTS = 200;

	typedef enum logic [1:0] {ST_WAIT, ST_FRONT, ST_PRESS, ST_REAR} btn_phase_t;

	typedef struct packed {
		logic [1:0] one_ev;
		logic [1:0] two_ev;
		logic [1:0] three_ev;
		logic       one_dn;
		logic       two_dn;
		logic       three_dn;
	} press_report_t;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [bdb_pkg::APB_AW-1:0] paddr;
	logic [bdb_pkg::APB_DW-1:0] pwdata;
	logic [bdb_pkg::APB_DW-1:0] prdata;
	logic                       pready;

	bdb_tick_if   tick();
	bdb_result_if result();

	button_short_long_press_debouncer_top #(.COUNT_WIDTH(CNT_W)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tick    (tick),
		.result  (result)
	);

	always #2 clk = ~clk;

	// predictor copy of registers and per-button state
	logic [bdb_pkg::BOUNCE_W-1:0] bounce_cfg;
	logic [bdb_pkg::HOLD_W-1:0]   hold_cfg;
	btn_phase_t                   btn_phase   [bdb_pkg::NUM_BUTTONS];
	logic [CNT_W-1:0]             btn_elapsed [bdb_pkg::NUM_BUTTONS];
	logic                         btn_down    [bdb_pkg::NUM_BUTTONS];

	logic [2:0]    tick_q[$];      // pending levels, bit 0 = button one
	press_report_t outcome_q[$];   // expected results, oldest first
	int            lane_pos [bdb_pkg::NUM_BUTTONS];
	int            send_idle_pct;
	int            recv_idle_pct;
	int            errors;

	function automatic press_report_t debounce_tick(logic [2:0] levels);
		logic [1:0]       ev [bdb_pkg::NUM_BUTTONS];
		logic [CNT_W-1:0] thr;
		logic             pressed;
		thr = (hold_cfg > bounce_cfg) ? hold_cfg - bounce_cfg : '0;
		for (int b = 0; b < bdb_pkg::NUM_BUTTONS; b++) begin
			pressed = !levels[b];
			ev[b] = bdb_pkg::EV_NONE;
			// every phase but waiting counts, saturating at all ones
			if (btn_phase[b] != ST_WAIT && btn_elapsed[b] != '1)
				btn_elapsed[b] = btn_elapsed[b] + 1'b1;
			case (btn_phase[b])
				ST_WAIT: begin
					if (pressed) begin
						btn_phase[b] = ST_FRONT;
						btn_down[b] = 1'b1;
						btn_elapsed[b] = '0;
					end
				end
				ST_FRONT: begin
					if (btn_elapsed[b] > bounce_cfg) begin
						btn_phase[b] = ST_PRESS;
						btn_elapsed[b] = '0;
					end
				end
				ST_PRESS: begin
					if (!pressed)
						ev[b] = bdb_pkg::EV_SHORT;
					else if (btn_elapsed[b] > thr)
						ev[b] = bdb_pkg::EV_LONG;
					if (ev[b] != bdb_pkg::EV_NONE) begin
						btn_phase[b] = ST_REAR;
						btn_down[b] = 1'b0;
						btn_elapsed[b] = '0;
					end
				end
				default: begin
					if (!pressed && btn_elapsed[b] > bounce_cfg)
						btn_phase[b] = ST_WAIT;
				end
			endcase
		end
		return '{ev[0], ev[1], ev[2], btn_down[0], btn_down[1], btn_down[2]};
	endfunction

	function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// tick driver
	always @(posedge clk) begin : tick_driver
		logic [2:0] lv;
		if (arst_n) begin
			if (tick.valid && tick.ready)
				outcome_q.push_back(debounce_tick({tick.pin_three_level,
					tick.pin_two_level, tick.pin_one_level}));
			if (!tick.valid || tick.ready) begin
				if (tick_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					lv = tick_q.pop_front();
					tick.valid <= 1'b1;
					tick.pin_one_level <= lv[0];
					tick.pin_two_level <= lv[1];
					tick.pin_three_level <= lv[2];
				end else begin
					tick.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : result_monitor
		press_report_t want;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (outcome_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: result transfer with nothing expected, %s %0d %0d %0d / %0b%0b%0b",
							$time, "got", result.one_event, result.two_event,
							result.three_event, result.one_down, result.two_down,
							result.three_down);
				end else begin
					want = outcome_q.pop_front();
					check_field("one_event", want.one_ev, result.one_event);
					check_field("two_event", want.two_ev, result.two_event);
					check_field("three_event", want.three_ev, result.three_event);
					check_field("one_down", 2'(want.one_dn), 2'(result.one_down));
					check_field("two_down", 2'(want.two_dn), 2'(result.two_down));
					check_field("three_down", 2'(want.three_dn), 2'(result.three_down));
				end
			end
			result.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// append n ticks of one level to one button's lane; other lanes default released
	task automatic put_level(int b, logic lvl, int n);
		logic [2:0] lv;
		repeat (n) begin
			if (lane_pos[b] >= tick_q.size())
				tick_q.push_back(3'b111);
			lv = tick_q[lane_pos[b]];
			lv[b] = lvl;
			tick_q[lane_pos[b]] = lv;
			lane_pos[b]++;
		end
	endtask

	// mostly whole presses of random length around the thresholds, some chatter
	task automatic random_presses(int len);
		int thr;
		thr = (hold_cfg > bounce_cfg) ? hold_cfg - bounce_cfg : 0;
		for (int b = 0; b < bdb_pkg::NUM_BUTTONS; b++) begin
			while (lane_pos[b] < len) begin
				if ($urandom_range(0, 9) < 2) begin
					repeat ($urandom_range(1, 6))
						put_level(b, 1'($urandom_range(0, 1)), 1);
				end else begin
					put_level(b, 1'b1, $urandom_range(0, bounce_cfg + 3));
					repeat ($urandom_range(0, 2))
						put_level(b, 1'($urandom_range(0, 1)), 1);
					put_level(b, 1'b0, $urandom_range(1, bounce_cfg + thr + 6));
					repeat ($urandom_range(0, 2))
						put_level(b, 1'($urandom_range(0, 1)), 1);
					put_level(b, 1'b1, $urandom_range(0, bounce_cfg + 4));
				end
			end
		end
	endtask

	task automatic wait_idle();
		while (tick_q.size() != 0 || tick.valid || outcome_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		for (int b = 0; b < bdb_pkg::NUM_BUTTONS; b++)
			lane_pos[b] = 0;
	endtask

	// upper data bits are random, the register keeps only its own width
	task automatic write_reg(logic idx, int unsigned value);
		logic [bdb_pkg::APB_DW-1:0] data;
		data = $urandom;
		if (idx == bdb_pkg::REG_BOUNCE)
			data[bdb_pkg::BOUNCE_W-1:0] = bdb_pkg::BOUNCE_W'(value);
		else
			data[bdb_pkg::HOLD_W-1:0] = bdb_pkg::HOLD_W'(value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == bdb_pkg::REG_BOUNCE)
			bounce_cfg = data[bdb_pkg::BOUNCE_W-1:0];
		else
			hold_cfg = data[bdb_pkg::HOLD_W-1:0];
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick.valid = 1'b0;
		tick.pin_one_level = 1'b1;
		tick.pin_two_level = 1'b1;
		tick.pin_three_level = 1'b1;
		result.ready = 1'b0;
		bounce_cfg = bdb_pkg::BOUNCE_RESET;
		hold_cfg = bdb_pkg::HOLD_RESET;
		errors = 0;
		for (int b = 0; b < bdb_pkg::NUM_BUTTONS; b++) begin
			btn_phase[b] = ST_WAIT;
			btn_elapsed[b] = '0;
			btn_down[b] = 1'b0;
			lane_pos[b] = 0;
		end
		send_idle_pct = 22;
		recv_idle_pct = 67;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: two short presses of different length, one-tick glitch
		put_level(0, 1'b0, 150);
		put_level(0, 1'b1, 110);
		put_level(1, 1'b0, 230);
		put_level(1, 1'b1, 30);
		put_level(2, 1'b0, 1);
		put_level(2, 1'b1, 259);
		wait_idle();

		// zero bounce and hold: long press on the first tick of the press phase
		write_reg(bdb_pkg::REG_BOUNCE, 0);
		write_reg(bdb_pkg::REG_HOLD, 0);
		put_level(0, 1'b0, 5);
		put_level(0, 1'b1, 3);
		put_level(1, 1'b0, 2);
		put_level(1, 1'b1, 3);
		repeat (4) begin
			put_level(2, 1'b0, 1);
			put_level(2, 1'b1, 1);
		end
		random_presses(60);
		wait_idle();

		write_reg(bdb_pkg::REG_BOUNCE, 1);
		write_reg(bdb_pkg::REG_HOLD, 1);
		random_presses(50);
		wait_idle();

		send_idle_pct = 67;
		recv_idle_pct = 22;
		write_reg(bdb_pkg::REG_BOUNCE, $urandom_range(0, 4));
		write_reg(bdb_pkg::REG_HOLD, $urandom_range(0, 12));
		random_presses(60);
		wait_idle();

		// hold below bounce
		write_reg(bdb_pkg::REG_BOUNCE, 5);
		write_reg(bdb_pkg::REG_HOLD, 3);
		random_presses(60);
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (2) begin
			write_reg(bdb_pkg::REG_BOUNCE, $urandom_range(0, 4));
			write_reg(bdb_pkg::REG_HOLD, $urandom_range(2, 12));
			random_presses(50);
			wait_idle();
		end

		// largest settings: presses stay in front bounce
		write_reg(bdb_pkg::REG_BOUNCE, 1023);
		write_reg(bdb_pkg::REG_HOLD, 65535);
		for (int b = 0; b < bdb_pkg::NUM_BUTTONS; b++) begin
			put_level(b, 1'b0, 20);
			put_level(b, 1'b1, 5);
		end
		wait_idle();

		repeat (4) @(posedge clk);
		if (errors == 0 && outcome_q.size() == 0)
			$display("PASS button_short_long_press_debouncer_top");
		else
			$display("FAIL button_short_long_press_debouncer_top");
		$finish;
	end

	initial begin
		#400000;
		$display("FAIL button_short_long_press_debouncer_top");
		$finish;
	end

endmodule
